// File: rtl/wmsd_pkg.sv
// Shared types and constants for the weighted mean square difference unit.
package wmsd_pkg;

    localparam int WSUM_W  = 28;
    localparam int SQSUM_W = 60;
    localparam int OUT_W   = 32;
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(SQSUM_W - 1);

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic        [15:0] weight;
        logic               x_missing;
        logic               y_missing;
        logic               last;
    } elem_t;

    typedef struct packed {
        logic [OUT_W-1:0] mean_square;
        logic             no_weight;
    } result_t;

    typedef struct packed {
        logic load;
        logic square;
        logic product;
        logic accumulate;
        logic div_start;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/wmsd_ctrl.sv
// Sequencer for element processing, run division and result hand-off.
module wmsd_ctrl
    import wmsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  elem_valid,
    output logic  elem_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SQUARE = 7'b0000010,
        S_PROD   = 7'b0000100,
        S_ACC    = 7'b0001000,
        S_DSTART = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (elem_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.product = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = stat.last ? S_DSTART : S_IDLE;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign elem_stall = (state_reg != S_IDLE);

endmodule

// File: rtl/wmsd_dp.sv
// Datapath: square and weight multiply, saturating sums, serial divider, output register.
module wmsd_dp
    import wmsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  elem_t   elem,
    input  cmd_t    cmd,
    output stat_t   stat,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic [15:0]        ad_reg;
    logic [15:0]        w_reg;
    logic               skip_reg;
    logic               last_reg;
    logic [31:0]        sq_reg;
    logic [47:0]        prod_reg;
    logic [WSUM_W-1:0]  wsum_reg;
    logic [WSUM_W-1:0]  wsum_next;
    logic [SQSUM_W-1:0] sqsum_reg;
    logic [SQSUM_W-1:0] sqsum_next;
    logic [SQSUM_W-1:0] div_reg;
    logic [WSUM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;

    logic signed [16:0] diff;
    logic [16:0]        ad_full;
    logic [WSUM_W:0]    wsum_add;
    logic [SQSUM_W:0]   sqsum_add;
    logic [WSUM_W:0]    trial;
    logic               ge;
    logic               zero_w;

    assign diff    = 17'(elem.x_value) - 17'(elem.y_value);
    assign ad_full = diff[16] ? 17'(-diff) : 17'(diff);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ad_reg   <= ad_full[15:0];
            w_reg    <= elem.weight;
            skip_reg <= elem.x_missing | elem.y_missing;
            last_reg <= elem.last;
        end
        if (cmd.square)
        begin
            sq_reg <= 32'(ad_reg) * 32'(ad_reg);
        end
        if (cmd.product)
        begin
            prod_reg <= 48'(sq_reg) * 48'(w_reg);
        end
    end

    assign wsum_add  = {1'b0, wsum_reg} + (WSUM_W + 1)'(w_reg);
    assign sqsum_add = {1'b0, sqsum_reg} + (SQSUM_W + 1)'(prod_reg);

    always_comb
    begin
        wsum_next  = wsum_reg;
        sqsum_next = sqsum_reg;
        if (cmd.emit)
        begin
            wsum_next  = '0;
            sqsum_next = '0;
        end
        else if (cmd.accumulate && !skip_reg)
        begin
            // saturate on carry out
            wsum_next  = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
            sqsum_next = sqsum_add[SQSUM_W] ? '1 : sqsum_add[SQSUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsum_reg  <= '0;
            sqsum_reg <= '0;
        end
        else
        begin
            wsum_reg  <= wsum_next;
            sqsum_reg <= sqsum_next;
        end
    end

    // restoring division, one quotient bit per cycle shifted into div_reg
    assign trial = {rem_reg, div_reg[SQSUM_W-1]};
    assign ge    = (trial >= {1'b0, wsum_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_reg <= sqsum_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? WSUM_W'(trial - {1'b0, wsum_reg}) : trial[WSUM_W-1:0];
            div_reg <= {div_reg[SQSUM_W-2:0], ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign zero_w = (wsum_reg == '0);

    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.no_weight <= zero_w;
            if (zero_w)
            begin
                out_reg.mean_square <= '0;
            end
            else if (|div_reg[SQSUM_W-1:OUT_W])
            begin
                out_reg.mean_square <= '1;
            end
            else
            begin
                out_reg.mean_square <= div_reg[OUT_W-1:0];
            end
        end
    end

    assign stat.last     = last_reg;
    assign stat.div_done = (cnt_reg == DIV_LAST_STEP);
    assign stat.out_free = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: rtl/weighted_mean_square_difference_unit.sv
// Weighted mean square difference unit, top level.
// Takes one (x, y, weight) word at a time and folds it into saturating
// weight and weighted-square sums; a word flagged last closes the run and
// yields weighted_square_sum / weight_sum as an unsigned integer (Q32.0),
// with no_weight set and zero returned when the weight sum is zero. Each
// word passes through the accept, square, weight multiply and accumulate
// steps in turn; the sequencer walks one word through the two registered
// multipliers before the next is taken. A last word then adds a divider
// setup step and the one-bit-per-cycle restoring divider, then the load of
// the output register, plus any time the output register is still held by
// the downstream stall. A result waiting in the output register does not
// block new words.
module weighted_mean_square_difference_unit
    import wmsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    elem_valid,
    output logic    elem_stall,
    input  elem_t   elem,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    cmd_t  cmd;
    stat_t stat;

    wmsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_stall (elem_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    wmsd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem         (elem),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
